// File: rtl/plst_pkg.sv
// Shared types and constants for the positional list store.
// Holds field widths, operation and status codes, and the cell control struct.
// No dependencies.
package plst_pkg;

   localparam int VALUE_W          = 32;
   localparam int POS_W            = 5;
   localparam int COUNT_W          = 5;
   localparam int OPCODE_W         = 2;
   localparam int STATUS_W         = 2;
   localparam int REQ_TDATA_W      = 40;
   localparam int RSP_TDATA_W      = 40;
   localparam int CAPACITY_DEFAULT = 16;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT  = 2'd0,
      OP_DELETE  = 2'd1,
      OP_READOUT = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_READ = 1'b1
   } fsm_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type         cmd;
      logic [VALUE_W-1:0]   value;
   } cell_ctl_type;

endpackage

// File: rtl/plst_cell.sv
// One storage cell of the positional list chain.
// Takes its own value, a neighbor's, the new value or the head, per command.
// Depends on plst_pkg.
module plst_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 4
) (
   input  logic                          clock,
   input  plst_pkg::cell_ctl_type        ctl,
   input  logic [IDX_W-1:0]              pos,
   input  logic [plst_pkg::VALUE_W-1:0]  left_data,
   input  logic [plst_pkg::VALUE_W-1:0]  right_data,
   input  logic [plst_pkg::VALUE_W-1:0]  head_data,
   output logic [plst_pkg::VALUE_W-1:0]  data
);
   import plst_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [VALUE_W-1:0] data_ff;
   logic [VALUE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.cmd)
         CELL_INSERT: begin
            if (MY_IDX == pos) begin
               data_in = ctl.value;
            end else if (MY_IDX > pos) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            if (MY_IDX >= pos) begin
               data_in = right_data;
            end
         end
         CELL_ROTATE: begin
            if (MY_IDX == pos) begin
               data_in = head_data;
            end else if (MY_IDX < pos) begin
               data_in = right_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// File: rtl/positional_list_store.sv
// Top level of the positional list store: control sequencer and cell chain.
// Depends on plst_pkg and plst_cell.
//
// Usage:
//   req channel: one transfer per operation; tdata holds opcode, position, value.
//   Insert, delete and unused opcodes give one rsp transfer with tlast high,
//   loaded into the output register at the edge the request is taken.
//   Readout of a list of N entries gives N rsp transfers, one per cycle while the
//   rsp side does not stall, the last with tlast high; an empty list
//   gives one transfer with status empty.
//   Insert and delete shift every cell at once; the next request can follow
//   straight after unless the rsp side stalls. Readout rotates the chain one step
//   per emitted entry through the single head tap and leaves it as it was.
//   Requests are held off while a readout runs.
//   Reset empties the list and drops any pending result; cell contents are not
//   cleared and are never read before being written.
//   A stalled rsp side holds the output register and the readout sequence;
//   a new request is taken in the same cycle the pending result transfers.
module positional_list_store #(
   parameter int CAPACITY = plst_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [1:0] opcode, [6:2] position, [38:7] value, [39] zero
   input  logic [plst_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] status, [33:2] element, [38:34] count, [39] zero
   output logic [plst_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast
);
   import plst_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;
   localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

   logic [OPCODE_W-1:0] req_opcode;
   logic [POS_W-1:0]    req_position;
   logic [VALUE_W-1:0]  req_value;

   assign req_opcode   = req_tdata[OPCODE_W-1:0];
   assign req_position = req_tdata[OPCODE_W+POS_W-1:OPCODE_W];
   assign req_value    = req_tdata[OPCODE_W+POS_W+VALUE_W-1:OPCODE_W+POS_W];

   fsm_type             state_ff, state_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff;
   logic [VALUE_W-1:0]  rsp_element_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_last_ff;

   logic                out_free;
   logic                req_xfer;
   logic                out_load;
   status_type          out_status;
   logic [VALUE_W-1:0]  out_element;
   logic                out_last;
   logic [CMP_W-1:0]    pos_cmp;
   logic [CMP_W-1:0]    len_cmp;
   logic [IDX_W-1:0]    tail_idx;
   logic                rd_at_tail;
   cell_ctl_type        cell_ctl;
   logic [IDX_W-1:0]    cell_pos;
   logic [VALUE_W-1:0]  cell_q [CAPACITY];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == FSM_IDLE) && out_free;
   assign req_xfer   = req_tvalid && req_tready;
   assign pos_cmp    = CMP_W'(req_position);
   assign len_cmp    = CMP_W'(len_ff);
   assign tail_idx   = IDX_W'(len_ff - 1'b1);
   assign rd_at_tail = (rd_idx_ff == tail_idx);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_xfer && req_opcode == OP_READOUT && len_ff != '0) begin
               state_in = FSM_READ;
            end
         end
         FSM_READ: begin
            if (out_free && rd_at_tail) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      cell_ctl.cmd   = CELL_HOLD;
      cell_ctl.value = req_value;
      cell_pos       = IDX_W'(req_position);
      len_in         = len_ff;
      rd_idx_in      = rd_idx_ff;
      out_load       = 1'b0;
      out_status     = ST_OK;
      out_element    = '0;
      out_last       = 1'b1;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_xfer) begin
               unique case (op_type'(req_opcode))
                  OP_INSERT: begin
                     out_load = 1'b1;
                     if (pos_cmp > len_cmp) begin
                        out_status = ST_INVALID;
                     end else if (len_ff == CAP_LEN) begin
                        out_status = ST_FULL;
                     end else begin
                        cell_ctl.cmd = CELL_INSERT;
                        len_in       = len_ff + 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     out_load = 1'b1;
                     if (len_ff == '0) begin
                        out_status = ST_EMPTY;
                     end else if (pos_cmp >= len_cmp) begin
                        out_status = ST_INVALID;
                     end else begin
                        cell_ctl.cmd = CELL_DELETE;
                        len_in       = len_ff - 1'b1;
                     end
                  end
                  OP_READOUT: begin
                     if (len_ff == '0) begin
                        out_load   = 1'b1;
                        out_status = ST_EMPTY;
                     end else begin
                        rd_idx_in = '0;
                     end
                  end
                  default: begin
                     out_load   = 1'b1;
                     out_status = ST_INVALID;
                  end
               endcase
            end
         end
         FSM_READ: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_element  = cell_q[0];
               out_last     = rd_at_tail;
               cell_ctl.cmd = CELL_ROTATE;
               cell_pos     = tail_idx;
               rd_idx_in    = rd_idx_ff + 1'b1;
            end
         end
         default: out_load = 1'b0;
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         len_ff       <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff  <= out_status;
         rsp_element_ff <= out_element;
         rsp_count_ff   <= COUNT_W'(len_in);
         rsp_last_ff    <= out_last;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] left_data;
      logic [VALUE_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = req_value;
      end else begin : g_inner_left
         assign left_data = cell_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_q[i];
      end else begin : g_inner_right
         assign right_data = cell_q[i+1];
      end

      plst_cell #(
         .INDEX (i),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .pos        (cell_pos),
         .left_data  (left_data),
         .right_data (right_data),
         .head_data  (cell_q[0]),
         .data       (cell_q[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_element_ff, rsp_status_ff};

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CAP_LEN)
      else $error("list length beyond capacity");

   a_no_req_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_READ |-> !req_tready)
      else $error("request taken during readout");

   a_read_continues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_READ && out_load && !out_last) |=> state_ff == FSM_READ)
      else $error("readout ended before last entry");

   a_len_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_READ) |=> len_ff == $past(len_ff))
      else $error("length changed during readout");
`endif

endmodule
